FILE: sv/rgbhsv_pkg.sv
// Shared types and constants for the RGB to HSV pixel converter.
package rgbhsv_pkg;

    localparam int PIX_W   = 8;
    localparam int STAGES  = 8;             // one quotient bit per cell
    localparam int REM_W   = 20;            // partial remainder width
    localparam int DIV_W   = 19;            // divisor pre-shifted by STAGES-1
    localparam int N_W     = 11;            // wrapped hue numerator, 0..1529
    localparam int LATENCY = 2 + STAGES;    // front end plus the cell row

    // Word handed from cell to cell: both divisions travel side by side.
    typedef struct packed {
        logic             vld;
        logic             grey;
        logic [PIX_W-1:0] value;
        logic [PIX_W-1:0] alpha;
        logic [REM_W-1:0] hrem;
        logic [REM_W-1:0] srem;
        logic [DIV_W-1:0] hdiv;
        logic [DIV_W-1:0] sdiv;
        logic [PIX_W-1:0] hq;
        logic [PIX_W-1:0] sq;
    } cell_word_t;

endpackage

FILE: sv/rgb_to_hsv_pixel.sv
// Top level: 8-bit RGBA to HSVA pixel converter, a front end and a row of divider cells.
// Pipeline: 2 front-end stages plus 8 division cells; the result strobe is the valid
// flag of the word leaving the last cell, and the result is taken while it is high.
// Throughput: one pixel per clock; busy is always low and the receiver cannot stall.
// Reset: rst_n clears all valid flags asynchronously; words in flight are dropped.
module rgb_to_hsv_pixel
    import rgbhsv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [PIX_W-1:0] red,
    input  logic [PIX_W-1:0] green,
    input  logic [PIX_W-1:0] blue,
    input  logic [PIX_W-1:0] alpha,
    output logic             done,
    output logic [PIX_W-1:0] hue,
    output logic [PIX_W-1:0] saturation,
    output logic [PIX_W-1:0] value,
    output logic [PIX_W-1:0] alpha_out
);

    cell_word_t chain [STAGES+1];

    assign busy = 1'b0;

    rgbhsv_prep u_prep (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .red   (red),
        .green (green),
        .blue  (blue),
        .alpha (alpha),
        .word  (chain[0])
    );

    for (genvar i = 0; i < STAGES; i++)
    begin : g_cell
        rgbhsv_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_word  (chain[i]),
            .out_word (chain[i+1])
        );
    end

    // A grey pixel has a zero hue divisor, so its quotient bits are discarded here.
    assign done       = chain[STAGES].vld;
    assign hue        = chain[STAGES].grey ? '0 : chain[STAGES].hq;
    assign saturation = chain[STAGES].grey ? '0 : chain[STAGES].sq;
    assign value      = chain[STAGES].value;
    assign alpha_out  = chain[STAGES].alpha;

endmodule

FILE: sv/rgbhsv_prep.sv
// Front end: channel max and min, sector numerator, and division operands.
module rgbhsv_prep
    import rgbhsv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [PIX_W-1:0] red,
    input  logic [PIX_W-1:0] green,
    input  logic [PIX_W-1:0] blue,
    input  logic [PIX_W-1:0] alpha,
    output cell_word_t       word
);

    logic             vld_reg, vld_next;
    logic             grey_reg, grey_next;
    logic [PIX_W-1:0] mx_reg, mx_next;
    logic [PIX_W-1:0] dl_reg, dl_next;
    logic [N_W-1:0]   n_reg, n_next;
    logic [PIX_W-1:0] alpha_reg, alpha_next;
    cell_word_t       word_reg, word_next;

    logic [PIX_W-1:0] mx, mn;
    logic signed [12:0] n_raw;
    logic signed [12:0] n_wrap;
    logic [REM_W-1:0] hnum, snum;

    always_comb
    begin
        mx = (red > green) ? red : green;
        mx = (mx > blue) ? mx : blue;
        mn = (red < green) ? red : green;
        mn = (mn < blue) ? mn : blue;
        dl_next = mx - mn;
        // Sector rule: the first channel equal to the max wins ties.
        if (red == mx)
        begin
            n_raw = $signed({5'd0, green}) - $signed({5'd0, blue});
        end
        else if (green == mx)
        begin
            n_raw = $signed({4'd0, dl_next, 1'b0}) + $signed({5'd0, blue})
                    - $signed({5'd0, red});
        end
        else
        begin
            n_raw = $signed({3'd0, dl_next, 2'b00}) + $signed({5'd0, red})
                    - $signed({5'd0, green});
        end
        n_wrap = n_raw;
        if (n_raw < 0)
        begin
            n_wrap = n_raw + $signed({3'd0, dl_next, 2'b00}) + $signed({4'd0, dl_next, 1'b0});
        end
        n_next     = n_wrap[N_W-1:0];
        mx_next    = mx;
        grey_next  = (dl_next == '0);
        vld_next   = start;
        alpha_next = alpha;
    end

    // Second stage: numerators 510*n + 6*delta and 510*delta + max, divisors shifted up.
    always_comb
    begin
        hnum = ({{(REM_W-N_W){1'b0}}, n_reg} << 9) - ({{(REM_W-N_W){1'b0}}, n_reg} << 1)
               + ({{(REM_W-PIX_W){1'b0}}, dl_reg} << 2)
               + ({{(REM_W-PIX_W){1'b0}}, dl_reg} << 1);
        snum = ({{(REM_W-PIX_W){1'b0}}, dl_reg} << 9) - ({{(REM_W-PIX_W){1'b0}}, dl_reg} << 1)
               + {{(REM_W-PIX_W){1'b0}}, mx_reg};
        word_next.vld   = vld_reg;
        word_next.grey  = grey_reg;
        word_next.value = mx_reg;
        word_next.alpha = alpha_reg;
        word_next.hrem  = hnum;
        word_next.srem  = snum;
        // 12*delta and 2*max, each shifted left by STAGES-1.
        word_next.hdiv  = ({{(DIV_W-PIX_W){1'b0}}, dl_reg} << 10)
                          + ({{(DIV_W-PIX_W){1'b0}}, dl_reg} << 9);
        word_next.sdiv  = {{(DIV_W-PIX_W){1'b0}}, mx_reg} << STAGES;
        word_next.hq    = '0;
        word_next.sq    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= 1'b0;
            word_reg <= '0;
        end
        else
        begin
            vld_reg  <= vld_next;
            word_reg <= word_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grey_reg  <= grey_next;
        mx_reg    <= mx_next;
        dl_reg    <= dl_next;
        n_reg     <= n_next;
        alpha_reg <= alpha_next;
    end

    assign word = word_reg;

endmodule

FILE: sv/rgbhsv_cell.sv
// One restoring division cell: decides one quotient bit of hue and of saturation.
module rgbhsv_cell
    import rgbhsv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_word_t in_word,
    output cell_word_t out_word
);

    cell_word_t       word_reg, word_next;
    logic             hbit, sbit;
    logic [REM_W-1:0] hsub, ssub;

    always_comb
    begin
        hbit = (in_word.hrem >= {1'b0, in_word.hdiv});
        sbit = (in_word.srem >= {1'b0, in_word.sdiv});
        hsub = hbit ? (in_word.hrem - {1'b0, in_word.hdiv}) : in_word.hrem;
        ssub = sbit ? (in_word.srem - {1'b0, in_word.sdiv}) : in_word.srem;
        word_next      = in_word;
        // After a subtract the remainder is below the divisor, so the shift cannot overflow.
        word_next.hrem = {hsub[REM_W-2:0], 1'b0};
        word_next.srem = {ssub[REM_W-2:0], 1'b0};
        word_next.hq   = {in_word.hq[PIX_W-2:0], hbit};
        word_next.sq   = {in_word.sq[PIX_W-2:0], sbit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else
        begin
            word_reg <= word_next;
        end
    end

    assign out_word = word_reg;

endmodule

FILE: sv/rgbhsv_checker.sv
// Port-level checker for the RGB to HSV pixel converter, bound to the top level.
module rgbhsv_checker
    import rgbhsv_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic [PIX_W-1:0] red,
    input logic [PIX_W-1:0] green,
    input logic [PIX_W-1:0] blue,
    input logic [PIX_W-1:0] alpha,
    input logic             done,
    input logic [PIX_W-1:0] hue,
    input logic [PIX_W-1:0] saturation,
    input logic [PIX_W-1:0] value,
    input logic [PIX_W-1:0] alpha_out
);

    // Every accepted word comes out after the fixed latency.
    a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted word did not produce a result");

    // No result without a matching accepted word.
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without an accepted word");

    // Alpha passes through with the pixel it belongs to.
    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (alpha_out == $past(alpha, LATENCY)))
        else $error("alpha does not match its pixel");

    // Zero saturation only happens for grey pixels, which have zero hue.
    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturation == '0) |-> (hue == '0))
        else $error("zero saturation with nonzero hue");

    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        (done && value == '0) |-> (saturation == '0))
        else $error("black pixel with nonzero saturation");

endmodule

bind rgb_to_hsv_pixel rgbhsv_checker u_rgbhsv_checker (.*);
